// ===== sv/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants of the first-fit capacity allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int unsigned AmountW = 32;
  localparam int unsigned BinW    = 11;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_ALLOC = 1'b1
  } cmd_e;

endpackage

// ===== sv/ffca_if.sv =====
// ----------------------------------------------------------------------------
// ffca_req_if / ffca_res_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface ffca_req_if;
  import ffca_pkg::*;

  logic                 valid;
  logic                 ready;
  cmd_e                 cmd;
  logic [AmountW-1:0]   amount;

  modport source (output valid, output cmd, output amount, input ready);
  modport sink   (input valid, input cmd, input amount, output ready);
endinterface

interface ffca_res_if;
  import ffca_pkg::*;

  logic              valid;
  logic              ready;
  logic [BinW-1:0]   bin_index;

  modport source (output valid, output bin_index, input ready);
  modport sink   (input valid, input bin_index, output ready);
endinterface

// ===== sv/ffca_ram.sv =====
// ----------------------------------------------------------------------------
// ffca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffca_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/first_fit_capacity_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_capacity_allocator_unit
// First-fit allocator over a max segment tree held in one node RAM.
// ----------------------------------------------------------------------------
// Request: root check, then if it fits a descent, leaf write and refresh up;
//   then the result. Load: leaf write, refresh up. No new item until done.
// The single node RAM read port walks one tree level per cycle, down and up.
// Reset clears the bin count and control state only; a node whose leftmost
//   bin is not loaded yet reads as zero, so no clearing pass is needed.
module first_fit_capacity_allocator_unit #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffca_req_if.sink     req_i,
  ffca_res_if.source   res_o
);
  import ffca_pkg::*;

  localparam int unsigned Levels = $clog2(LEAVES);
  localparam int unsigned Span   = 1 << Levels;
  localparam int unsigned Depth  = 2 * Span;
  localparam int unsigned NodeW  = Levels + 1;
  localparam int unsigned LvlW   = $clog2(Levels + 1);
  localparam int unsigned CntW   = $clog2(LEAVES + 1);
  localparam int unsigned IdxW   = (Levels + 1 > BinW) ? Levels + 1 : BinW;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ROOT = 6'b000010,
    ST_DESC = 6'b000100,
    ST_LEAF = 6'b001000,
    ST_UP   = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic                alloc_q, alloc_d;
  logic [AmountW-1:0]  amount_q, amount_d;
  logic [AmountW-1:0]  val_q, val_d;
  logic [NodeW-1:0]    cur_q, cur_d;
  logic [LvlW-1:0]     lvl_q, lvl_d;
  logic [NodeW-1:0]    rd_addr_q, rd_addr_d;
  logic [LvlW-1:0]     rd_lvl_q, rd_lvl_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [BinW-1:0]     res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [BinW-1:0]     out_bin_q, out_bin_d;

  logic                we;
  logic [NodeW-1:0]    waddr;
  logic [AmountW-1:0]  wdata;
  logic [AmountW-1:0]  rdata;

  logic [LvlW-1:0]     shift_amt;
  logic [NodeW-1:0]    shifted;
  logic [Levels-1:0]   leaf_off;
  logic [AmountW-1:0]  node_val;
  logic [NodeW-1:0]    nxt;
  logic [LvlW-1:0]     lvl_nx;
  logic [NodeW-1:0]    leaf_addr;
  logic [NodeW-1:0]    parent;
  logic [AmountW-1:0]  up_max;
  logic [IdxW-1:0]     bin_wide;

  ffca_ram #(
    .Width (AmountW),
    .Depth (Depth)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr_d),
    .rdata_o (rdata)
  );

  // Nodes whose leftmost bin is beyond the loaded count read as zero.
  assign shift_amt = LvlW'(Levels) - rd_lvl_q;
  assign shifted   = rd_addr_q << shift_amt;
  assign leaf_off  = shifted[Levels-1:0];
  assign node_val  = (CntW'(leaf_off) < count_q) ? rdata : '0;

  assign nxt       = {cur_q[NodeW-2:0], (node_val < amount_q)};
  assign lvl_nx    = lvl_q + 1'b1;
  assign leaf_addr = {1'b1, count_q[Levels-1:0]};
  assign parent    = cur_q >> 1;
  assign up_max    = (node_val > val_q) ? node_val : val_q;
  assign bin_wide  = IdxW'(cur_q[Levels-1:0]) + IdxW'(1);

  assign res_o.valid     = out_valid_q;
  assign res_o.bin_index = out_bin_q;

  always_comb begin
    state_d     = state_q;
    alloc_d     = alloc_q;
    amount_d    = amount_q;
    val_d       = val_q;
    cur_d       = cur_q;
    lvl_d       = lvl_q;
    rd_addr_d   = rd_addr_q;
    rd_lvl_d    = rd_lvl_q;
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_bin_d   = out_bin_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    req_i.ready = 1'b0;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.cmd == CMD_ALLOC) begin
            alloc_d   = 1'b1;
            amount_d  = req_i.amount;
            rd_addr_d = NodeW'(1);
            rd_lvl_d  = '0;
            state_d   = ST_ROOT;
          end else begin
            alloc_d = 1'b0;
            if (count_q < CntW'(LEAVES)) begin
              we        = 1'b1;
              waddr     = leaf_addr;
              wdata     = req_i.amount;
              val_d     = req_i.amount;
              cur_d     = leaf_addr;
              lvl_d     = LvlW'(Levels);
              rd_addr_d = leaf_addr ^ NodeW'(1);
              rd_lvl_d  = LvlW'(Levels);
              count_d   = count_q + 1'b1;
              state_d   = ST_UP;
            end
          end
        end
      end
      ST_ROOT: begin
        if (node_val < amount_q) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          cur_d     = NodeW'(1);
          lvl_d     = '0;
          rd_addr_d = NodeW'(2);
          rd_lvl_d  = LvlW'(1);
          state_d   = ST_DESC;
        end
      end
      ST_DESC: begin
        cur_d = nxt;
        lvl_d = lvl_nx;
        if (lvl_nx == LvlW'(Levels)) begin
          rd_addr_d = nxt;
          rd_lvl_d  = lvl_nx;
          state_d   = ST_LEAF;
        end else begin
          rd_addr_d = {nxt[NodeW-2:0], 1'b0};
          rd_lvl_d  = lvl_nx + 1'b1;
        end
      end
      ST_LEAF: begin
        we        = 1'b1;
        waddr     = cur_q;
        wdata     = node_val - amount_q;
        val_d     = node_val - amount_q;
        res_d     = bin_wide[BinW-1:0];
        lvl_d     = LvlW'(Levels);
        rd_addr_d = cur_q ^ NodeW'(1);
        rd_lvl_d  = LvlW'(Levels);
        state_d   = ST_UP;
      end
      ST_UP: begin
        we    = 1'b1;
        waddr = parent;
        wdata = up_max;
        val_d = up_max;
        if (lvl_q == LvlW'(1)) begin
          state_d = alloc_q ? ST_DONE : ST_IDLE;
        end else begin
          cur_d     = parent;
          lvl_d     = lvl_q - 1'b1;
          rd_addr_d = parent ^ NodeW'(1);
          rd_lvl_d  = lvl_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_bin_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      alloc_q     <= 1'b0;
      cur_q       <= '0;
      lvl_q       <= '0;
      rd_addr_q   <= '0;
      rd_lvl_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alloc_q     <= alloc_d;
      cur_q       <= cur_d;
      lvl_q       <= lvl_d;
      rd_addr_q   <= rd_addr_d;
      rd_lvl_q    <= rd_lvl_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amount_q  <= amount_d;
    val_q     <= val_d;
    res_q     <= res_d;
    out_bin_q <= out_bin_d;
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(LEAVES))
    else $error("bin count above LEAVES");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> waddr != rd_addr_d)
    else $error("node read and write hit the same entry");

  a_up_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UP |-> lvl_q != '0)
    else $error("refresh level underflow");

  a_root_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT |=> state_q == ST_DESC || state_q == ST_DONE)
    else $error("bad step after root check");
`endif

endmodule
